>>> hw/rtl/lsrc_pkg.sv
`default_nettype none

package lsrc_pkg;

   localparam int COORD_WIDTH     = 32;
   localparam int FRAC_BITS       = 16;
   localparam int STYLE_WIDTH     = 6;
   localparam int SHAPE_WIDTH     = 2;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int MAX_PASSES      = 4;
   localparam int JOB_DEPTH       = 2;
   localparam int RSP_DEPTH       = 2;

   localparam logic [STYLE_WIDTH-1:0] SHAPE_MASK = STYLE_WIDTH'(3);

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   localparam coord_type WINDOW_ONE = coord_type'(64'd1 << FRAC_BITS);

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_WINDOW_LEFT   = 2'd0,
      CSR_WINDOW_BOTTOM = 2'd1,
      CSR_WINDOW_RIGHT  = 2'd2,
      CSR_WINDOW_TOP    = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_SELECT,
      ENG_MUL,
      ENG_DIVCHK,
      ENG_DIV,
      ENG_APPLY,
      ENG_DONE
   } eng_state_type;

   typedef struct packed {
      coord_type left;
      coord_type bottom;
      coord_type right;
      coord_type top;
   } win_type;

   typedef struct packed {
      coord_type                inside_x;
      coord_type                inside_y;
      coord_type                far_x;
      coord_type                far_y;
      logic [STYLE_WIDTH-1:0]   line_style;
      logic                     want_marker;
   } req_type;

   typedef struct packed {
      coord_type                inside_x;
      coord_type                inside_y;
      coord_type                far_x;
      coord_type                far_y;
      logic [STYLE_WIDTH-1:0]   line_style;
      logic                     want_marker;
      logic [SHAPE_WIDTH-1:0]   marker_shape;
      logic                     start_outside;
   } job_type;

   typedef struct packed {
      coord_type                start_x;
      coord_type                start_y;
      coord_type                end_x;
      coord_type                end_y;
      logic [STYLE_WIDTH-1:0]   style_out;
      logic                     draw_marker;
      logic [SHAPE_WIDTH-1:0]   marker_shape;
      logic                     start_outside;
   } rsp_type;

endpackage

`default_nettype wire

>>> hw/rtl/line_segment_rect_clip_unit.sv
// A segment that needs no clipping passes from the job queue through select to done;
// a clipping pass runs setup, 3 multiply steps, a range check, 32 divide steps and
// an update, skips the divide steps when the quotient overflows, and skips both the
// multiply and divide steps when the segment has no extent along the moved axis; up to four passes.
// The engine works on one request at a time with its radix-2 divider; later requests wait in the job queue.
// Reset is synchronous and active high; it empties both queues, idles the engine
// and loads the window with left and bottom 0.0, right and top 1.0.
`default_nettype none

module line_segment_rect_clip_unit
   import lsrc_pkg::*;
#(
   parameter int JOB_QUEUE_DEPTH = JOB_DEPTH,
   parameter int RSP_QUEUE_DEPTH = RSP_DEPTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire req_type                    req_data,
   output logic                            full,
   input  wire logic                       pop,
   output rsp_type                         rsp_data,
   output logic                            empty,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [COORD_WIDTH-1:0]     csr_wdata
);

   win_type win_ff, win_in;

   job_type job;
   logic    job_empty, job_pop;
   rsp_type rsp_new;
   logic    rsp_push, rsp_full;
   logic [$bits(rsp_type)-1:0] rsp_bits;

   assign csr_ready = 1'b1;

   always_comb begin
      win_in = win_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_WINDOW_LEFT:   win_in.left   = coord_type'(csr_wdata);
            CSR_WINDOW_BOTTOM: win_in.bottom = coord_type'(csr_wdata);
            CSR_WINDOW_RIGHT:  win_in.right  = coord_type'(csr_wdata);
            CSR_WINDOW_TOP:    win_in.top    = coord_type'(csr_wdata);
            default:           win_in        = win_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff.left   <= '0;
         win_ff.bottom <= '0;
         win_ff.right  <= WINDOW_ONE;
         win_ff.top    <= WINDOW_ONE;
      end else begin
         win_ff <= win_in;
      end
   end

   lsrc_front #(
      .DEPTH (JOB_QUEUE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req       (req_data),
      .win       (win_ff),
      .full      (full),
      .job_pop   (job_pop),
      .job       (job),
      .job_empty (job_empty)
   );

   lsrc_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .win       (win_ff),
      .job       (job),
      .job_empty (job_empty),
      .job_pop   (job_pop),
      .rsp       (rsp_new),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push)
   );

   lsrc_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_new),
      .full  (rsp_full),
      .pop   (pop),
      .rdata (rsp_bits),
      .empty (empty)
   );

   assign rsp_data = rsp_type'(rsp_bits);

endmodule

`default_nettype wire

>>> hw/rtl/lsrc_fifo.sv
`default_nettype none

module lsrc_fifo
   import lsrc_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rdata,
   output logic                  empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
   localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == COUNT_FULL);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/lsrc_front.sv
`default_nettype none

module lsrc_front
   import lsrc_pkg::*;
#(
   parameter int DEPTH = JOB_DEPTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire req_type req,
   input  wire win_type win,
   output logic         full,
   input  wire logic    job_pop,
   output job_type      job,
   output logic         job_empty
);

   job_type                  job_new;
   logic [$bits(job_type)-1:0] job_bits;

   // The start point is flagged when it lies beyond any edge of the window.
   always_comb begin
      job_new.inside_x      = req.inside_x;
      job_new.inside_y      = req.inside_y;
      job_new.far_x         = req.far_x;
      job_new.far_y         = req.far_y;
      job_new.line_style    = req.line_style;
      job_new.want_marker   = req.want_marker;
      job_new.marker_shape  = SHAPE_WIDTH'(req.line_style & SHAPE_MASK);
      job_new.start_outside = (req.inside_x < win.left) || (req.inside_x > win.right) ||
                              (req.inside_y < win.bottom) || (req.inside_y > win.top);
   end

   lsrc_fifo #(
      .WIDTH ($bits(job_type)),
      .DEPTH (DEPTH)
   ) u_job_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (job_new),
      .full  (full),
      .pop   (job_pop),
      .rdata (job_bits),
      .empty (job_empty)
   );

   assign job = job_type'(job_bits);

endmodule

`default_nettype wire

>>> hw/rtl/lsrc_engine.sv
`default_nettype none

module lsrc_engine
   import lsrc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire win_type win,
   input  wire job_type job,
   input  wire logic    job_empty,
   output logic         job_pop,
   output rsp_type      rsp,
   input  wire logic    rsp_full,
   output logic         rsp_push
);

   localparam int W         = COORD_WIDTH;
   localparam int DW        = W + 1;
   localparam int PW        = 2 * DW;
   localparam int MUL_CHUNK = 16;
   localparam int NCH       = (DW + MUL_CHUNK - 1) / MUL_CHUNK;
   localparam int BPW       = NCH * MUL_CHUNK;
   localparam int CW        = $clog2(W);
   localparam int PASS_W    = $clog2(MAX_PASSES + 1);

   localparam logic [CW-1:0]     MUL_LAST   = CW'(NCH - 1);
   localparam logic [CW-1:0]     DIV_LAST   = CW'(W - 1);
   localparam logic [PASS_W-1:0] PASS_LIMIT = PASS_W'(MAX_PASSES);
   localparam coord_type         SAT_MAX    = coord_type'({1'b0, {(W-1){1'b1}}});
   localparam coord_type         SAT_MIN    = coord_type'({1'b1, {(W-1){1'b0}}});

   function automatic logic [DW-1:0] mag_f(input logic signed [DW-1:0] v);
      logic signed [DW-1:0] n;
      n = -v;
      return v[DW-1] ? DW'(n) : DW'(v);
   endfunction

   eng_state_type state_ff, state_in;

   job_type           job_ff, job_in;
   coord_type         xo_ff, xo_in;
   coord_type         yo_ff, yo_in;
   logic [PASS_W-1:0] pass_ff, pass_in;
   logic [DW-1:0]     a_ff, a_in;
   logic [BPW-1:0]    b_ff, b_in;
   logic [DW-1:0]     den_ff, den_in;
   logic              neg_ff, neg_in;
   logic              zero_ff, zero_in;
   logic              ovf_ff, ovf_in;
   logic              move_x_ff, move_x_in;
   coord_type         base_ff, base_in;
   coord_type         edge_ff, edge_in;
   logic [PW-1:0]     prod_ff, prod_in;
   logic [DW-1:0]     rem_ff, rem_in;
   logic [W-1:0]      quo_ff, quo_in;
   logic [CW-1:0]     cnt_ff, cnt_in;

   // Pass setup terms.
   logic                 clip_sel;
   logic                 move_x_sel;
   coord_type            edge_sel;
   coord_type            move_near, move_far, other_near, other_far;
   logic signed [DW-1:0] other_d, edge_d, move_d;

   // Arithmetic terms.
   logic [DW+MUL_CHUNK-1:0] partial;
   logic [W+1:0]            prod_hi;
   logic [DW:0]             trial;
   logic                    trial_ge;
   logic [W-1:0]            quot;
   logic signed [W+1:0]     base_x, quot_x, sum;
   coord_type               result;

   always_comb begin
      clip_sel   = 1'b1;
      move_x_sel = 1'b1;
      edge_sel   = win.left;
      priority if (xo_ff < win.left) begin
         move_x_sel = 1'b1;
         edge_sel   = win.left;
      end else if (yo_ff < win.bottom) begin
         move_x_sel = 1'b0;
         edge_sel   = win.bottom;
      end else if (xo_ff > win.right) begin
         move_x_sel = 1'b1;
         edge_sel   = win.right;
      end else if (yo_ff > win.top) begin
         move_x_sel = 1'b0;
         edge_sel   = win.top;
      end else begin
         clip_sel = 1'b0;
      end

      move_near  = move_x_sel ? job_ff.inside_x : job_ff.inside_y;
      move_far   = move_x_sel ? xo_ff : yo_ff;
      other_near = move_x_sel ? job_ff.inside_y : job_ff.inside_x;
      other_far  = move_x_sel ? yo_ff : xo_ff;
      other_d    = DW'(other_far) - DW'(other_near);
      edge_d     = DW'(edge_sel) - DW'(move_near);
      move_d     = DW'(move_far) - DW'(move_near);
   end

   always_comb begin
      partial  = a_ff * b_ff[BPW-1 -: MUL_CHUNK];
      prod_hi  = prod_ff[PW-1:W];
      trial    = {rem_ff, quo_ff[W-1]};
      trial_ge = (trial >= {1'b0, den_ff});
      quot     = zero_ff ? '0 : quo_ff;
      base_x   = (W+2)'(base_ff);
      quot_x   = signed'({2'b00, quot});
      sum      = neg_ff ? (base_x - quot_x) : (base_x + quot_x);
      if (ovf_ff) begin
         result = neg_ff ? SAT_MIN : SAT_MAX;
      end else if ((sum[W+1] == sum[W]) && (sum[W] == sum[W-1])) begin
         result = coord_type'(sum[W-1:0]);
      end else begin
         result = sum[W+1] ? SAT_MIN : SAT_MAX;
      end
   end

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      xo_in     = xo_ff;
      yo_in     = yo_ff;
      pass_in   = pass_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      den_in    = den_ff;
      neg_in    = neg_ff;
      zero_in   = zero_ff;
      ovf_in    = ovf_ff;
      move_x_in = move_x_ff;
      base_in   = base_ff;
      edge_in   = edge_ff;
      prod_in   = prod_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      job_pop   = 1'b0;
      rsp_push  = 1'b0;

      unique case (state_ff)
         ENG_IDLE: begin
            if (!job_empty) begin
               job_pop  = 1'b1;
               job_in   = job;
               xo_in    = job.far_x;
               yo_in    = job.far_y;
               pass_in  = '0;
               state_in = ENG_SELECT;
            end
         end
         ENG_SELECT: begin
            if ((pass_ff == PASS_LIMIT) || !clip_sel) begin
               state_in = ENG_DONE;
            end else begin
               a_in      = mag_f(other_d);
               b_in      = BPW'(mag_f(edge_d));
               den_in    = mag_f(move_d);
               neg_in    = other_d[DW-1] ^ edge_d[DW-1] ^ move_d[DW-1];
               zero_in   = (move_d == '0);
               ovf_in    = 1'b0;
               move_x_in = move_x_sel;
               base_in   = other_near;
               edge_in   = edge_sel;
               prod_in   = '0;
               cnt_in    = MUL_LAST;
               // A segment with no extent along the moving axis keeps the
               // other coordinate, so the product and quotient are skipped.
               state_in  = (move_d == '0) ? ENG_APPLY : ENG_MUL;
            end
         end
         ENG_MUL: begin
            prod_in = {prod_ff[PW-MUL_CHUNK-1:0], {MUL_CHUNK{1'b0}}} + PW'(partial);
            b_in    = {b_ff[BPW-MUL_CHUNK-1:0], {MUL_CHUNK{1'b0}}};
            if (cnt_ff == '0) begin
               state_in = ENG_DIVCHK;
            end else begin
               cnt_in = cnt_ff - CW'(1);
            end
         end
         ENG_DIVCHK: begin
            // A quotient that does not fit the coordinate width saturates.
            if (prod_hi >= (W+2)'(den_ff)) begin
               ovf_in   = 1'b1;
               state_in = ENG_APPLY;
            end else begin
               rem_in   = prod_hi[DW-1:0];
               quo_in   = prod_ff[W-1:0];
               cnt_in   = DIV_LAST;
               state_in = ENG_DIV;
            end
         end
         ENG_DIV: begin
            rem_in = trial_ge ? DW'(trial - {1'b0, den_ff}) : trial[DW-1:0];
            quo_in = {quo_ff[W-2:0], trial_ge};
            if (cnt_ff == '0) begin
               state_in = ENG_APPLY;
            end else begin
               cnt_in = cnt_ff - CW'(1);
            end
         end
         ENG_APPLY: begin
            if (move_x_ff) begin
               xo_in = edge_ff;
               yo_in = result;
            end else begin
               xo_in = result;
               yo_in = edge_ff;
            end
            pass_in  = pass_ff + PASS_W'(1);
            state_in = ENG_SELECT;
         end
         ENG_DONE: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = ENG_IDLE;
            end
         end
         default: begin
            state_in = ENG_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff    <= job_in;
      xo_ff     <= xo_in;
      yo_ff     <= yo_in;
      pass_ff   <= pass_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      den_ff    <= den_in;
      neg_ff    <= neg_in;
      zero_ff   <= zero_in;
      ovf_ff    <= ovf_in;
      move_x_ff <= move_x_in;
      base_ff   <= base_in;
      edge_ff   <= edge_in;
      prod_ff   <= prod_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
   end

   always_comb begin
      rsp.start_x       = job_ff.inside_x;
      rsp.start_y       = job_ff.inside_y;
      rsp.end_x         = xo_ff;
      rsp.end_y         = yo_ff;
      rsp.style_out     = job_ff.line_style;
      rsp.draw_marker   = job_ff.want_marker;
      rsp.marker_shape  = job_ff.marker_shape;
      rsp.start_outside = job_ff.start_outside;
   end

endmodule

`default_nettype wire

>>> sim/line_segment_rect_clip_unit_tb.sv
`default_nettype none

module line_segment_rect_clip_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lsrc_pkg::*;

   localparam coord_type C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam coord_type C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   localparam coord_type HALF  = WINDOW_ONE / 2;

   // Keeps the window copy, predicts clipped segments and checks them in order.
   class clip_scoreboard;
      coord_type win_left, win_bottom, win_right, win_top;
      rsp_type   ends_due[$];
      int        mismatches;

      function new();
         win_left   = '0;
         win_bottom = '0;
         win_right  = WINDOW_ONE;
         win_top    = WINDOW_ONE;
         mismatches = 0;
      endfunction

      function void set_window(csr_index_type idx, coord_type v);
         case (idx)
            CSR_WINDOW_LEFT:   win_left   = v;
            CSR_WINDOW_BOTTOM: win_bottom = v;
            CSR_WINDOW_RIGHT:  win_right  = v;
            CSR_WINDOW_TOP:    win_top    = v;
         endcase
      endfunction

      function longint magnitude(longint v);
         return (v < 0) ? -v : v;
      endfunction

      // Moves one coordinate by similar triangles: base + other * span / move.
      function longint slide_to_edge(longint other_d, longint span_d, longint move_d,
                                     longint base);
         logic [127:0] prod, quo;
         longint       offs, hi_lim, lo_lim;
         logic         flip;
         hi_lim = (longint'(1) << (COORD_WIDTH-1)) - 1;
         lo_lim = -hi_lim - 1;
         if (move_d == 0) return base;
         prod = 128'(magnitude(other_d)) * 128'(magnitude(span_d));
         quo  = prod / 128'(magnitude(move_d));
         // Huge quotients are clamped well above the coordinate range.
         if (quo > (128'd1 << 62)) quo = 128'd1 << 62;
         offs = longint'(quo[63:0]);
         flip = ((other_d < 0) != (span_d < 0)) != (move_d < 0);
         offs = flip ? base - offs : base + offs;
         if (offs > hi_lim) return hi_lim;
         if (offs < lo_lim) return lo_lim;
         return offs;
      endfunction

      function rsp_type clip_segment(req_type r);
         longint  xl, yb, xr, yt, x, y, xo, yo;
         rsp_type e;
         xl = win_left;
         yb = win_bottom;
         xr = win_right;
         yt = win_top;
         x  = r.inside_x;
         y  = r.inside_y;
         xo = r.far_x;
         yo = r.far_y;
         for (int pass = 0; pass < MAX_PASSES; pass++) begin
            if (xo < xl) begin
               yo = slide_to_edge(yo - y, xl - x, xo - x, y);
               xo = xl;
            end else if (yo < yb) begin
               xo = slide_to_edge(xo - x, yb - y, yo - y, x);
               yo = yb;
            end else if (xo > xr) begin
               yo = slide_to_edge(yo - y, xr - x, xo - x, y);
               xo = xr;
            end else if (yo > yt) begin
               xo = slide_to_edge(xo - x, yt - y, yo - y, x);
               yo = yt;
            end else begin
               break;
            end
         end
         e.start_x       = coord_type'(x);
         e.start_y       = coord_type'(y);
         e.end_x         = coord_type'(xo);
         e.end_y         = coord_type'(yo);
         e.style_out     = r.line_style;
         e.draw_marker   = r.want_marker;
         e.marker_shape  = SHAPE_WIDTH'(r.line_style & SHAPE_MASK);
         e.start_outside = (x < xl) || (x > xr) || (y < yb) || (y > yt);
         return e;
      endfunction

      function void note_request(req_type r);
         ends_due.push_back(clip_segment(r));
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= 40) $display("ERROR at %0t ns: %s", $time, msg);
      endtask

      task check_field(string name, longint got, longint want);
         if (got != want) report($sformatf("%s is %0d, expected %0d", name, got, want));
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (ends_due.size() == 0) begin
            report("result popped with no request outstanding");
            return;
         end
         want = ends_due.pop_front();
         check_field("start_x", got.start_x, want.start_x);
         check_field("start_y", got.start_y, want.start_y);
         check_field("end_x", got.end_x, want.end_x);
         check_field("end_y", got.end_y, want.end_y);
         check_field("style_out", got.style_out, want.style_out);
         check_field("draw_marker", got.draw_marker, want.draw_marker);
         check_field("marker_shape", got.marker_shape, want.marker_shape);
         check_field("start_outside", got.start_outside, want.start_outside);
      endtask
   endclass

   logic                       clock;
   logic                       reset;
   logic                       push;
   req_type                    req_data;
   logic                       full;
   logic                       pop;
   rsp_type                    rsp_data;
   logic                       empty;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [COORD_WIDTH-1:0]     csr_wdata;

   clip_scoreboard board;
   int             rsp_hold_cycles = 0;
   int             burst_left = 0;

   line_segment_rect_clip_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_data  (req_data),
      .full      (full),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .empty     (empty),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty) board.check_result(rsp_data);
   end

   // Result side: switches between stall patterns, and honors a long hold-off on demand.
   initial begin : receiver
      int mode, left;
      pop <= 1'b0;
      mode = 0;
      left = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            pop <= 1'b0;
            rsp_hold_cycles = rsp_hold_cycles - 1;
         end else begin
            if (left == 0) begin
               mode = $urandom_range(0, 3);
               left = $urandom_range(16, 160);
            end
            left--;
            case (mode)
               0: pop <= 1'b1;
               1: pop <= 1'($urandom);
               2: pop <= (left % 4 == 0);
               default: pop <= ($urandom_range(0, 9) == 0);
            endcase
         end
      end
   end

   function automatic req_type seg(input coord_type ix, iy, fx, fy,
                                   input logic [STYLE_WIDTH-1:0] style, input logic marker);
      req_type q;
      q.inside_x    = ix;
      q.inside_y    = iy;
      q.far_x       = fx;
      q.far_y       = fy;
      q.line_style  = style;
      q.want_marker = marker;
      return q;
   endfunction

   function automatic coord_type rand_coord();
      return coord_type'($urandom);
   endfunction

   // Uniform value between two bounds, in either order, clamped to the coordinate range.
   function automatic coord_type rand_span(longint lo, longint hi);
      longint          tmp;
      longint unsigned u;
      if (hi < lo) begin
         tmp = lo;
         lo  = hi;
         hi  = tmp;
      end
      if (lo < longint'(C_MIN)) lo = C_MIN;
      if (hi > longint'(C_MAX)) hi = C_MAX;
      if (lo > longint'(C_MAX)) lo = C_MAX;
      if (hi < longint'(C_MIN)) hi = C_MIN;
      u = {$urandom, $urandom};
      return coord_type'(lo + longint'(u % longint'(hi - lo + 1)));
   endfunction

   function automatic req_type make_segment();
      longint  l, b, r, t, w, h;
      req_type q;
      int      pick;
      l = board.win_left;
      b = board.win_bottom;
      r = board.win_right;
      t = board.win_top;
      w = ((r > l) ? r - l : l - r) + 1;
      h = ((t > b) ? t - b : b - t) + 1;
      q = seg(rand_span(l, r), rand_span(b, t), rand_span(l - 2 * w, r + 2 * w),
              rand_span(b - 2 * h, t + 2 * h), 6'($urandom), 1'($urandom));
      pick = $urandom_range(0, 9);
      if (pick >= 6 && pick <= 7) begin
         q.far_x = rand_coord();
         q.far_y = rand_coord();
      end else if (pick == 8) begin
         q.inside_x = rand_coord();
         q.inside_y = rand_coord();
         q.far_x    = rand_coord();
         q.far_y    = rand_coord();
      end else if (pick == 9) begin
         // Degenerate moves and endpoints sitting exactly on an edge.
         case ($urandom_range(0, 2))
            0: q.far_x = q.inside_x;
            1: q.far_y = q.inside_y;
            default: begin
               q.far_x = $urandom_range(0, 1) ? board.win_left : board.win_right;
               q.far_y = $urandom_range(0, 1) ? board.win_bottom : board.win_top;
            end
         endcase
      end
      return q;
   endfunction

   task automatic offer(req_type r);
      push     <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (full);
      board.note_request(r);
   endtask

   task automatic send(req_type r);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      offer(r);
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      while (board.ends_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, coord_type v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      board.set_window(idx, v);
   endtask

   task automatic program_window(coord_type l, coord_type b, coord_type r, coord_type t);
      wait_drained();
      write_reg(CSR_WINDOW_LEFT, l);
      write_reg(CSR_WINDOW_BOTTOM, b);
      write_reg(CSR_WINDOW_RIGHT, r);
      write_reg(CSR_WINDOW_TOP, t);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random(int count);
      repeat (count) send(make_segment());
   endtask

   initial begin : stimulus
      coord_type a, b, c, d;
      reset     <= 1'b1;
      push      <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_WINDOW_LEFT;
      csr_wdata <= '0;
      board = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Unit window after reset: each edge, corners, degenerate moves, saturation.
      send(seg(HALF, HALF, HALF / 2, 3 * HALF / 2, 0, 0));
      send(seg(HALF, HALF, -WINDOW_ONE, HALF, 63, 1));
      send(seg(HALF, HALF / 2, HALF, -2 * WINDOW_ONE, 1, 0));
      send(seg(HALF / 2, HALF, 3 * WINDOW_ONE, 3 * HALF / 2, 2, 1));
      send(seg(HALF, HALF, HALF / 2, 5 * WINDOW_ONE, 3, 0));
      send(seg(HALF, HALF, 2 * WINDOW_ONE, 3 * WINDOW_ONE, 42, 1));
      send(seg(HALF, HALF, -3 * WINDOW_ONE, -WINDOW_ONE, 21, 0));
      send(seg(-WINDOW_ONE, HALF, -WINDOW_ONE, 2 * WINDOW_ONE, 5, 1));
      send(seg(HALF / 2, -WINDOW_ONE, 3 * HALF / 2, -WINDOW_ONE, 6, 0));
      send(seg(C_MAX, 0, C_MAX - 1, C_MAX, 7, 1));
      send(seg(C_MAX, C_MIN, C_MAX - 1, C_MAX, 8, 0));
      send(seg(C_MIN, C_MIN, C_MAX, C_MAX, 63, 1));
      send(seg(C_MAX, C_MAX, C_MIN, C_MIN, 0, 0));
      send(seg(0, 0, 0, 0, 0, 0));
      send(seg(HALF, HALF, WINDOW_ONE, WINDOW_ONE, 13, 1));
      send(seg(2 * WINDOW_ONE, HALF, HALF, HALF, 50, 0));
      send(seg(HALF, 2 * WINDOW_ONE, C_MIN, C_MAX, 33, 1));
      send(seg(-1, -1, -2, 1, 62, 1));
      send_random(100);

      program_window(-100 * WINDOW_ONE, -50 * WINDOW_ONE, 200 * WINDOW_ONE, 75 * WINDOW_ONE);
      send_random(120);

      // Hold the result side off while requests keep coming, so the input backs up.
      wait_drained();
      rsp_hold_cycles = 400;
      repeat (20) offer(make_segment());
      wait_drained();

      program_window(C_MIN, C_MIN, C_MAX, C_MAX);
      send_random(100);

      // Inverted window: clipping may never settle within the pass limit.
      program_window(WINDOW_ONE, WINDOW_ONE, -WINDOW_ONE, -WINDOW_ONE);
      send_random(80);

      program_window(5 * WINDOW_ONE, -3 * WINDOW_ONE, 5 * WINDOW_ONE, -3 * WINDOW_ONE);
      send_random(80);

      program_window(0, 0, 1, 1);
      send_random(80);

      repeat (2) begin
         a = rand_coord() >>> $urandom_range(0, 16);
         b = rand_coord() >>> $urandom_range(0, 16);
         c = rand_coord() >>> $urandom_range(0, 16);
         d = rand_coord() >>> $urandom_range(0, 16);
         program_window((a < c) ? a : c, (b < d) ? b : d, (a < c) ? c : a, (b < d) ? d : b);
         send_random(80);
      end

      program_window(C_MAX, C_MAX, C_MIN, C_MIN);
      send_random(60);

      wait_drained();
      repeat (160) @(posedge clock);
      if (board.mismatches == 0 && board.ends_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
